FILE: hdl/rwtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rwtu_pkg;

    // Ticks of the 90 kHz timeline in one second
    localparam logic [31:0] TICKS_PER_SEC = 32'd90000;

    // Register reset values
    localparam logic [31:0] THRESHOLD_RST = 32'd0;
    localparam logic [31:0] PERIOD_NUM_RST = 32'd1;
    localparam logic [31:0] PERIOD_DEN_RST = 32'd30;
    localparam logic [31:0] BIT_RATE_RST = 32'd1000000;

    // Register indexes on the configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_NUM = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_DEN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_RATE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_DIS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MERGE_DIS = 3'd5;

    // Bit-serial divider: dividend register width and step counts
    localparam int unsigned DIV_W = 64;
    localparam int unsigned PROD_BITS = 49;
    localparam logic [5:0] STEPS_PROD = 6'd49;
    localparam logic [5:0] STEPS_WORD = 6'd32;

endpackage

`default_nettype wire

FILE: hdl/rate_window_timing_update.sv
`timescale 1ns / 1ps
`default_nettype none

// Rate window timing update: one item per encoded frame.
// Input channel (in_valid / in_stall) carries frame_bits. Output channel
// (out_valid / out_stall) carries one result item per input item: both
// timelines with their remainders, removed seconds and running totals.
// Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
// always taken; write them only while no item is in flight.
// One shared restoring divider does the divisions and retires one
// quotient bit per cycle: 49 + 32 steps per timeline and 32 steps for
// the seconds removal, between the setup, merge and output states.
// An item with a zero divisor skips the divider and finishes with error set.
// One item is worked at a time; in_stall is high while one is in work, so
// a new item is taken only after the last has been handed to the output.
// The result sits in an output register, so the next item is taken while
// it waits; a finished item then holds until the receiver drops out_stall.
// Reset clears all timelines and totals and loads the register defaults.
module rate_window_timing_update (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [rwtu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] frame_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             error,
    output logic [31:0]      transmit_ticks,
    output logic [31:0]      transmit_fraction,
    output logic [31:0]      schedule_ticks,
    output logic [31:0]      schedule_fraction,
    output logic [15:0]      seconds_removed_now,
    output logic [31:0]      seconds_removed_total,
    output logic [31:0]      clamp_ticks_total,
    output logic [31:0]      frames_seen,
    output logic [63:0]      bits_total
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIV_TX1,
        ST_POST_TX1,
        ST_DIV_TX2,
        ST_POST_TX2,
        ST_DIV_SC1,
        ST_POST_SC1,
        ST_DIV_SC2,
        ST_POST_SC2,
        ST_DIV_CUT,
        ST_POST_CUT,
        ST_MRG_A,
        ST_MRG_B,
        ST_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [31:0] threshold_reg;
    logic [31:0] period_num_reg;
    logic [31:0] period_den_reg;
    logic [31:0] bit_rate_reg;
    logic        clamp_dis_reg;
    logic        merge_dis_reg;

    // Architectural state
    logic [31:0] tx_time_reg;
    logic [31:0] tx_rem_reg;
    logic [31:0] sc_time_reg;
    logic [31:0] sc_rem_reg;
    logic [31:0] removed_total_reg;
    logic [31:0] clamp_total_reg;
    logic [31:0] frame_count_reg;
    logic [63:0] bit_sum_reg;

    // Working values for the item in flight
    logic [31:0] bits_reg;
    logic [31:0] tx_w_reg;
    logic [31:0] sc_w_reg;
    logic [31:0] tx_rem_w_reg;
    logic [31:0] sc_rem_w_reg;
    logic [15:0] removed_reg;
    logic        err_reg;
    logic [63:0] prod_reg;

    // Bit-serial divider
    logic [rwtu_pkg::DIV_W-1:0] div_q_reg;
    logic [31:0] div_rem_reg;
    logic [31:0] div_d_reg;
    logic [5:0]  div_cnt_reg;
    logic [32:0] div_t;
    logic        div_ge;
    logic [32:0] div_diff;
    logic [31:0] div_rem_next;

    // Shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // Misc combinational values
    logic [31:0] floor_val;
    logic [31:0] sc_adv;
    logic [31:0] lower_val;
    logic        merge_take;
    logic        in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Divider step: shift one dividend bit into the remainder
    always_comb
    begin
        div_t = {div_rem_reg, div_q_reg[rwtu_pkg::DIV_W-1]};
        div_ge = (div_t >= {1'b0, div_d_reg});
        div_diff = div_t - {1'b0, div_d_reg};
        div_rem_next = div_ge ? div_diff[31:0] : div_t[31:0];
    end

    // Select multiplier operands by step
    always_comb
    begin
        unique case (state_reg)
            ST_CLAMP:
            begin
                mul_a = bits_reg;
                mul_b = rwtu_pkg::TICKS_PER_SEC;
            end
            ST_POST_TX2:
            begin
                mul_a = period_num_reg;
                mul_b = rwtu_pkg::TICKS_PER_SEC;
            end
            ST_POST_CUT:
            begin
                mul_a = {16'd0, div_q_reg[15:0]};
                mul_b = rwtu_pkg::TICKS_PER_SEC;
            end
            ST_MRG_A:
            begin
                mul_a = bit_rate_reg;
                mul_b = sc_rem_w_reg;
            end
            default:
            begin
                mul_a = tx_rem_w_reg;
                mul_b = period_den_reg;
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb
    begin
        floor_val = sc_time_reg - threshold_reg;
        sc_adv = sc_w_reg + div_q_reg[31:0];
        lower_val = (sc_adv < tx_w_reg) ? sc_adv : tx_w_reg;
        merge_take = !merge_dis_reg && ((sc_w_reg < tx_w_reg) ||
            ((sc_w_reg == tx_w_reg) && (prod_reg < mul_p)));
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            threshold_reg <= rwtu_pkg::THRESHOLD_RST;
            period_num_reg <= rwtu_pkg::PERIOD_NUM_RST;
            period_den_reg <= rwtu_pkg::PERIOD_DEN_RST;
            bit_rate_reg <= rwtu_pkg::BIT_RATE_RST;
            clamp_dis_reg <= 1'b0;
            merge_dis_reg <= 1'b0;
            tx_time_reg <= '0;
            tx_rem_reg <= '0;
            sc_time_reg <= '0;
            sc_rem_reg <= '0;
            removed_total_reg <= '0;
            clamp_total_reg <= '0;
            frame_count_reg <= '0;
            bit_sum_reg <= '0;
            div_cnt_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    rwtu_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                    rwtu_pkg::REG_PERIOD_NUM: period_num_reg <= cfg_data;
                    rwtu_pkg::REG_PERIOD_DEN: period_den_reg <= cfg_data;
                    rwtu_pkg::REG_BIT_RATE: bit_rate_reg <= cfg_data;
                    rwtu_pkg::REG_CLAMP_DIS: clamp_dis_reg <= cfg_data[0];
                    rwtu_pkg::REG_MERGE_DIS: merge_dis_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            // Drop the result once taken
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        bits_reg <= frame_bits;
                        removed_reg <= '0;
                        if (bit_rate_reg == 32'd0 || period_den_reg == 32'd0)
                        begin
                            err_reg <= 1'b1;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            err_reg <= 1'b0;
                            state_reg <= ST_CLAMP;
                        end
                    end
                end
                ST_CLAMP:
                begin
                    // Raise transmit to schedule minus threshold
                    if (!clamp_dis_reg && (tx_time_reg < floor_val))
                    begin
                        clamp_total_reg <= clamp_total_reg + (floor_val - tx_time_reg);
                        tx_w_reg <= floor_val;
                    end
                    else
                    begin
                        tx_w_reg <= tx_time_reg;
                    end
                    sc_w_reg <= sc_time_reg;
                    div_q_reg <= {mul_p[rwtu_pkg::PROD_BITS-1:0],
                        {(rwtu_pkg::DIV_W - rwtu_pkg::PROD_BITS){1'b0}}};
                    div_rem_reg <= '0;
                    div_d_reg <= bit_rate_reg;
                    div_cnt_reg <= rwtu_pkg::STEPS_PROD;
                    state_reg <= ST_DIV_TX1;
                end
                ST_DIV_TX1, ST_DIV_TX2, ST_DIV_SC1, ST_DIV_SC2, ST_DIV_CUT:
                begin
                    // Advance the divider one quotient bit
                    div_q_reg <= {div_q_reg[rwtu_pkg::DIV_W-2:0], div_ge};
                    div_rem_reg <= div_rem_next;
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd1)
                    begin
                        unique case (state_reg)
                            ST_DIV_TX1: state_reg <= ST_POST_TX1;
                            ST_DIV_TX2: state_reg <= ST_POST_TX2;
                            ST_DIV_SC1: state_reg <= ST_POST_SC1;
                            ST_DIV_SC2: state_reg <= ST_POST_SC2;
                            default: state_reg <= ST_POST_CUT;
                        endcase
                    end
                end
                ST_POST_TX1:
                begin
                    tx_w_reg <= tx_w_reg + div_q_reg[31:0];
                    div_q_reg <= {tx_rem_reg + div_rem_reg, 32'd0};
                    div_rem_reg <= '0;
                    div_cnt_reg <= rwtu_pkg::STEPS_WORD;
                    state_reg <= ST_DIV_TX2;
                end
                ST_POST_TX2:
                begin
                    tx_w_reg <= tx_w_reg + div_q_reg[31:0];
                    tx_rem_w_reg <= div_rem_reg;
                    div_q_reg <= {mul_p[rwtu_pkg::PROD_BITS-1:0],
                        {(rwtu_pkg::DIV_W - rwtu_pkg::PROD_BITS){1'b0}}};
                    div_rem_reg <= '0;
                    div_d_reg <= period_den_reg;
                    div_cnt_reg <= rwtu_pkg::STEPS_PROD;
                    state_reg <= ST_DIV_SC1;
                end
                ST_POST_SC1:
                begin
                    sc_w_reg <= sc_w_reg + div_q_reg[31:0];
                    div_q_reg <= {sc_rem_reg + div_rem_reg, 32'd0};
                    div_rem_reg <= '0;
                    div_cnt_reg <= rwtu_pkg::STEPS_WORD;
                    state_reg <= ST_DIV_SC2;
                end
                ST_POST_SC2:
                begin
                    sc_w_reg <= sc_adv;
                    sc_rem_w_reg <= div_rem_reg;
                    // Divide the headroom above threshold by one second
                    div_rem_reg <= '0;
                    div_d_reg <= rwtu_pkg::TICKS_PER_SEC;
                    div_cnt_reg <= rwtu_pkg::STEPS_WORD;
                    if ((threshold_reg < sc_adv) && (threshold_reg < tx_w_reg))
                    begin
                        div_q_reg <= {lower_val - threshold_reg, 32'd0};
                        state_reg <= ST_DIV_CUT;
                    end
                    else
                    begin
                        div_q_reg <= '0;
                        state_reg <= ST_POST_CUT;
                    end
                end
                ST_POST_CUT:
                begin
                    // Remove whole seconds from both timelines
                    removed_reg <= div_q_reg[15:0];
                    tx_w_reg <= tx_w_reg - mul_p[31:0];
                    sc_w_reg <= sc_w_reg - mul_p[31:0];
                    state_reg <= ST_MRG_A;
                end
                ST_MRG_A:
                begin
                    prod_reg <= mul_p;
                    state_reg <= ST_MRG_B;
                end
                ST_MRG_B:
                begin
                    // Commit the step; schedule adopts transmit when behind
                    tx_time_reg <= tx_w_reg;
                    removed_total_reg <= removed_total_reg + {16'd0, removed_reg};
                    frame_count_reg <= frame_count_reg + 32'd1;
                    bit_sum_reg <= bit_sum_reg + {32'd0, bits_reg};
                    if (merge_take)
                    begin
                        sc_time_reg <= tx_w_reg;
                        sc_rem_reg <= tx_rem_w_reg;
                    end
                    else
                    begin
                        sc_time_reg <= sc_w_reg;
                        sc_rem_reg <= sc_rem_w_reg;
                        tx_rem_reg <= tx_rem_w_reg;
                    end
                    state_reg <= ST_FIN;
                end
                default:
                begin
                    // Hold until the output register is free
                    if (!out_valid || !out_stall)
                    begin
                        out_valid <= 1'b1;
                        error <= err_reg;
                        transmit_ticks <= tx_time_reg;
                        transmit_fraction <= tx_rem_reg;
                        schedule_ticks <= sc_time_reg;
                        schedule_fraction <= sc_rem_reg;
                        seconds_removed_now <= removed_reg;
                        seconds_removed_total <= removed_total_reg;
                        clamp_ticks_total <= clamp_total_reg;
                        frames_seen <= frame_count_reg;
                        bits_total <= bit_sum_reg;
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // A divider state never runs with an empty step count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_TX1 || state_reg == ST_DIV_TX2 || state_reg == ST_DIV_SC1 ||
         state_reg == ST_DIV_SC2 || state_reg == ST_DIV_CUT) |-> (div_cnt_reg != 6'd0))
        else $error("divider running with zero count");

    // An error result removes no seconds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (seconds_removed_now == 16'd0))
        else $error("error result reports removed seconds");

    // An accepted item starts work at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("accepted item not started");

endmodule

`default_nettype wire

FILE: tb/rwtu_checker.sv
`timescale 1ns / 1ps

module rwtu_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [rwtu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [31:0] frame_bits,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        error,
    input  wire logic [31:0] transmit_ticks,
    input  wire logic [31:0] transmit_fraction,
    input  wire logic [31:0] schedule_ticks,
    input  wire logic [31:0] schedule_fraction,
    input  wire logic [15:0] seconds_removed_now,
    input  wire logic [31:0] seconds_removed_total,
    input  wire logic [31:0] clamp_ticks_total,
    input  wire logic [31:0] frames_seen,
    input  wire logic [63:0] bits_total,
    output int               fail_count,
    output int               pending_count,
    output int               frames_checked,
    output int               error_frames,
    output int               merges_seen,
    output int               removals_seen
);
    import rwtu_pkg::*;

    typedef struct packed {
        logic        err;
        logic [31:0] tx_ticks;
        logic [31:0] tx_frac;
        logic [31:0] sc_ticks;
        logic [31:0] sc_frac;
        logic [15:0] rm_now;
        logic [31:0] rm_total;
        logic [31:0] clamp_total;
        logic [31:0] frames;
        logic [63:0] bit_sum;
    } timing_t;

    timing_t timing_fifo[$];

    // shadow registers
    logic [31:0] thresh, per_num, per_den, rate;
    logic        clamp_off, merge_off;

    // shadow state
    logic [31:0] tx_t, tx_r, sc_t, sc_r, rm_tot, clamp_tot, frame_cnt;
    logic [63:0] bit_acc;

    // Advance one timeline by amount*90000/div with exact remainder
    task automatic advance_line(input logic [31:0] amount, input logic [31:0] div,
                                input logic [31:0] old_rem, inout logic [31:0] ticks,
                                output logic [31:0] new_rem);
        logic [63:0] prod;
        logic [31:0] sum;
        prod = 64'(amount) * 64'(TICKS_PER_SEC);
        sum = old_rem + 32'(prod % 64'(div));
        new_rem = sum % div;
        ticks = ticks + sum / div + 32'(prod / 64'(div));
    endtask

    task automatic predict_timing(input logic [31:0] bits, output timing_t exp_t);
        logic [31:0] tx, sc, txr, scr, lift_floor, lower, rm_now;
        rm_now = '0;
        exp_t.err = 1'b0;
        if (rate == 0 || per_den == 0) begin
            exp_t.err = 1'b1;
        end else begin
            tx = tx_t;
            sc = sc_t;
            if (!clamp_off) begin
                lift_floor = sc - thresh;
                if (tx < lift_floor) begin
                    clamp_tot = clamp_tot + (lift_floor - tx);
                    tx = lift_floor;
                end
            end
            advance_line(bits, rate, tx_r, tx, txr);
            advance_line(per_num, per_den, sc_r, sc, scr);
            if (thresh < sc && thresh < tx) begin
                lower = (sc < tx) ? sc : tx;
                rm_now = (lower - thresh) / TICKS_PER_SEC;
                tx = tx - rm_now * TICKS_PER_SEC;
                sc = sc - rm_now * TICKS_PER_SEC;
                if (rm_now != 0) removals_seen++;
            end
            rm_tot = rm_tot + rm_now;
            frame_cnt = frame_cnt + 1;
            bit_acc = bit_acc + 64'(bits);
            tx_t = tx;
            if (!merge_off && (sc < tx || (sc == tx &&
                (64'(rate) * 64'(scr) < 64'(txr) * 64'(per_den))))) begin
                sc_t = tx;
                sc_r = txr;
                merges_seen++;
            end else begin
                sc_t = sc;
                tx_r = txr;
                sc_r = scr;
            end
        end
        exp_t.tx_ticks = tx_t;
        exp_t.tx_frac = tx_r;
        exp_t.sc_ticks = sc_t;
        exp_t.sc_frac = sc_r;
        exp_t.rm_now = rm_now[15:0];
        exp_t.rm_total = rm_tot;
        exp_t.clamp_total = clamp_tot;
        exp_t.frames = frame_cnt;
        exp_t.bit_sum = bit_acc;
    endtask

    always @(posedge clk or negedge rst_n) begin
        timing_t exp_t, got;
        if (!rst_n) begin
            thresh = THRESHOLD_RST;
            per_num = PERIOD_NUM_RST;
            per_den = PERIOD_DEN_RST;
            rate = BIT_RATE_RST;
            clamp_off = 1'b0;
            merge_off = 1'b0;
            tx_t = '0; tx_r = '0; sc_t = '0; sc_r = '0;
            rm_tot = '0; clamp_tot = '0; frame_cnt = '0; bit_acc = '0;
            timing_fifo.delete();
            fail_count = 0;
            pending_count = 0;
            frames_checked = 0;
            error_frames = 0;
            merges_seen = 0;
            removals_seen = 0;
        end else begin
            // compare the oldest expectation first, then queue new work
            if (out_valid && !out_stall) begin
                got = '{error, transmit_ticks, transmit_fraction, schedule_ticks,
                        schedule_fraction, seconds_removed_now, seconds_removed_total,
                        clamp_ticks_total, frames_seen, bits_total};
                if (timing_fifo.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result item %p", $realtime, got);
                end else begin
                    exp_t = timing_fifo.pop_front();
                    frames_checked++;
                    if (got !== exp_t) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: result mismatch\n  exp %p\n  got %p",
                                     $realtime, exp_t, got);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                predict_timing(frame_bits, exp_t);
                if (exp_t.err) error_frames++;
                timing_fifo.push_back(exp_t);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD:  thresh = cfg_data;
                    REG_PERIOD_NUM: per_num = cfg_data;
                    REG_PERIOD_DEN: per_den = cfg_data;
                    REG_BIT_RATE:   rate = cfg_data;
                    REG_CLAMP_DIS:  clamp_off = cfg_data[0];
                    REG_MERGE_DIS:  merge_off = cfg_data[0];
                    default: ;
                endcase
            end
            pending_count = timing_fifo.size();
        end
    end

endmodule

FILE: tb/tb_rate_window_timing_update.sv
`timescale 1ns / 1ps

module tb_rate_window_timing_update;
    import rwtu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] frame_bits;
    logic        out_valid;
    logic        out_stall;
    logic        error;
    logic [31:0] transmit_ticks, transmit_fraction, schedule_ticks, schedule_fraction;
    logic [15:0] seconds_removed_now;
    logic [31:0] seconds_removed_total, clamp_ticks_total, frames_seen;
    logic [63:0] bits_total;

    int fail_count, pending_count, frames_checked, error_frames;
    int merges_seen, removals_seen;
    int idle_cycles;
    bit stall_random;
    bit long_hold;
    bit calm_phase;

    rate_window_timing_update uut (.*);

    rwtu_checker checker_i (.*);

    // clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stall: random, with a calm stretch and one long hold
    always @(negedge clk) begin
        if (long_hold)
            out_stall <= 1'b1;
        else if (stall_random && !calm_phase)
            out_stall <= ($urandom_range(99) < 24);
        else
            out_stall <= 1'b0;
    end

    // watchdog: count cycles with nothing accepted
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d items pending", pending_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait out every expected item, then the block's own latency
    task automatic drain_block();
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] th, input logic [31:0] pn,
                               input logic [31:0] pd, input logic [31:0] br,
                               input logic cd, input logic md);
        drain_block();
        write_reg(REG_THRESHOLD, th);
        write_reg(REG_PERIOD_NUM, pn);
        write_reg(REG_PERIOD_DEN, pd);
        write_reg(REG_BIT_RATE, br);
        write_reg(REG_CLAMP_DIS, {31'd0, cd});
        write_reg(REG_MERGE_DIS, {31'd0, md});
    endtask

    task automatic send_frame(input logic [31:0] bits, input bit gaps);
        @(negedge clk);
        while (gaps && !calm_phase && $urandom_range(99) < 24) @(negedge clk);
        in_valid <= 1'b1;
        frame_bits <= bits;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // mostly frame-sized counts, some full range
    function automatic logic [31:0] pick_bits();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(31);
            default: return $urandom_range(400000);
        endcase
    endfunction

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        frame_bits = '0;
        out_stall = 1'b0;
        stall_random = 1'b0;
        long_hold = 1'b0;
        calm_phase = 1'b0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, field extremes
        send_frame(32'd0, 1'b0);
        send_frame(32'hFFFF_FFFF, 1'b0);
        send_frame(32'd33333, 1'b0);
        send_frame(32'h5555_5555, 1'b0);
        send_frame(32'hAAAA_AAAA, 1'b0);
        // zero divisors give error
        load_config(32'd0, 32'd1, 32'd0, 32'd1000000, 1'b0, 1'b0);
        send_frame(32'd1000, 1'b0);
        load_config(32'd0, 32'd1, 32'd30, 32'd0, 1'b0, 1'b0);
        send_frame(32'd1000, 1'b0);
        // huge threshold with clamp and merge off; all-ones registers
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_frame(32'hFFFF_FFFF, 1'b0);
        send_frame(32'd1, 1'b0);
        // rate 1 gives wide quotient truncation and seconds removal
        load_config(32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 1'b0, 1'b0);
        send_frame(32'hFFFF_FFFF, 1'b0);
        send_frame(32'd7, 1'b0);
        // equal ticks: the remainder cross-product breaks the tie
        load_config(32'd0, 32'd1, 32'd3, 32'd3, 1'b0, 1'b0);
        send_frame(32'd1, 1'b0);
        send_frame(32'd2, 1'b0);
        send_frame(32'd0, 1'b0);
        // clamp lifts transmit when schedule runs ahead
        load_config(32'd1000, 32'd1, 32'd1, 32'd1000000, 1'b0, 1'b1);
        send_frame(32'd0, 1'b0);
        send_frame(32'd0, 1'b0);
        send_frame(32'd0, 1'b0);

        // random phases across configurations
        stall_random = 1'b1;
        for (int ph = 0; ph < 14; ph++) begin
            case (ph % 4)
                0: load_config($urandom_range(200000), $urandom_range(1, 9),
                               $urandom_range(1, 60), $urandom_range(1000, 8000000),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
                1: load_config($urandom, $urandom, $urandom, $urandom,
                               1'($urandom_range(1)), 1'($urandom_range(1)));
                2: load_config($urandom_range(3), $urandom_range(1, 3),
                               $urandom_range(1, 3), $urandom_range(1, 3),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
                default: load_config($urandom_range(90000), 32'd1001, 32'd30000,
                                     ($urandom_range(9) == 0) ? 32'd0 : 32'd2000000,
                                     1'b0, 1'b0);
            endcase
            calm_phase = (ph == 3);
            // receiver holds off while the sender keeps offering
            if (ph == 5) begin
                fork
                    begin
                        long_hold = 1'b1;
                        repeat (800) @(posedge clk);
                        long_hold = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 100; k++) begin
                send_frame(pick_bits(), 1'b1);
                // sender waits for the block to empty
                if (ph == 7 && k == 50) begin
                    @(posedge clk);
                    while (pending_count != 0) @(posedge clk);
                end
            end
        end
        calm_phase = 1'b0;

        drain_block();
        $display("checked %0d frames (%0d zero-divisor, %0d merges, %0d with removal)",
                 frames_checked, error_frames, merges_seen, removals_seen);
        $display("register sets covered defaults, zero divisors, all-ones and tiny ratios");
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
